FILE: design/itb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itb_pkg
// Shared constants, types and the elaboration-time sine table builder.
// ----------------------------------------------------------------------------
package itb_pkg;

  localparam int ITB_TRIG_FRAC_BITS = 30;
  localparam int ITB_LAT            = 14;

  localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q60   = 64'h1000000000000000;
  localparam logic [63:0] STEP_Q60  = PI_Q60 / 180;

  typedef logic [63:0] rom_t [91];

  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Restoring long division, truncating.
  function automatic logic [63:0] div_small(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] taylor(logic [63:0] x, logic cosine);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] d;
    x2   = mul_q60(x, x);
    term = cosine ? ONE_Q60 : x;
    sum  = term;
    for (int k = 1; k <= 7; k++) begin
      d    = cosine ? 64'((2 * k - 1) * (2 * k)) : 64'((2 * k) * (2 * k + 1));
      term = div_small(mul_q60(term, x2), d);
      if ((k & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic rom_t build_sin_rom(int frac);
    rom_t        rom;
    logic [63:0] v;
    for (int r = 0; r <= 90; r++) begin
      if (r <= 45) begin
        v = taylor(STEP_Q60 * 64'(r), 1'b0);
      end else begin
        v = taylor(STEP_Q60 * 64'(90 - r), 1'b1);
      end
      v = (v + (64'd1 << (59 - frac))) >> (60 - frac);
      rom[r] = v;
    end
    return rom;
  endfunction

endpackage

FILE: design/instance_transform_builder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// instance_transform_builder_top
// Builds a scaled 3x4 placement transform from position, angles and scale.
// ----------------------------------------------------------------------------
// The block takes one placement beat in every clock cycle (busy_o is always
// low) and presents its transform for one cycle, marked by valid_o, after
// the 14-stage matrix datapath. The receiver cannot stall the block, so every
// result must be taken when shown.
module instance_transform_builder_top #(
  parameter int TRIG_FRAC_BITS = itb_pkg::ITB_TRIG_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [31:0]        angle_x_i,
  input  logic [31:0]        angle_y_i,
  input  logic [31:0]        angle_z_i,
  input  logic [5:0]         scale_code_a_i,
  input  logic [5:0]         scale_code_b_i,
  input  logic [5:0]         scale_code_c_i,
  input  logic               uniform_flag_i,
  output logic               valid_o,
  output logic signed [31:0] m00_o,
  output logic signed [31:0] m01_o,
  output logic signed [31:0] m02_o,
  output logic signed [31:0] m10_o,
  output logic signed [31:0] m11_o,
  output logic signed [31:0] m12_o,
  output logic signed [31:0] m20_o,
  output logic signed [31:0] m21_o,
  output logic signed [31:0] m22_o,
  output logic signed [31:0] trans_x_o,
  output logic signed [31:0] trans_y_o,
  output logic signed [31:0] trans_z_o
);
  import itb_pkg::*;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } trn_t;

  logic [ITB_LAT-1:0] vld_q;
  logic [17:0]        num [3];
  logic signed [31:0] m [9];
  logic [31:0]        ymag;
  logic [29:0]        ym_q;
  logic [60:0]        yp;
  logic [25:0]        yq_q;
  logic               yneg1_q, yneg2_q;
  logic [31:0]        px1_q, pz1_q, px2_q, pz2_q;
  trn_t               trn_q [ITB_LAT-2];

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[ITB_LAT-2:0], start_i};
    end
  end

  always_comb begin
    if (uniform_flag_i) begin
      num[0] = {scale_code_c_i, scale_code_b_i, scale_code_a_i};
      num[1] = {scale_code_c_i, scale_code_b_i, scale_code_a_i};
      num[2] = {scale_code_c_i, scale_code_b_i, scale_code_a_i};
    end else begin
      num[0] = 18'(scale_code_a_i);
      num[1] = 18'(scale_code_b_i);
      num[2] = 18'(scale_code_c_i);
    end
    ymag = pos_y_i[31] ? 32'(-pos_y_i) : 32'(pos_y_i);
    yp   = 61'(ym_q) * 61'd1374389535;
  end

  itb_xform #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_xform (
    .clk_i    (clk_i),
    .angle_x_i(angle_x_i),
    .angle_y_i(angle_y_i),
    .angle_z_i(angle_z_i),
    .num_i    (num),
    .uni_i    (uniform_flag_i),
    .m_o      (m)
  );

  always_ff @(posedge clk_i) begin
    ym_q    <= 30'((ymag + 32'd50) >> 2);
    yneg1_q <= pos_y_i[31];
    px1_q   <= pos_x_i;
    pz1_q   <= pos_z_i;
    yq_q    <= yp[60:35];
    yneg2_q <= yneg1_q;
    px2_q   <= px1_q;
    pz2_q   <= pz1_q;
    trn_q[0] <= '{x: px2_q,
                  y: yneg2_q ? -32'(yq_q) : 32'(yq_q),
                  z: pz2_q};
    for (int k = 1; k < ITB_LAT - 2; k++) begin
      trn_q[k] <= trn_q[k-1];
    end
  end

  assign valid_o   = vld_q[ITB_LAT-1];
  assign m00_o     = m[0];
  assign m01_o     = m[1];
  assign m02_o     = m[2];
  assign m10_o     = m[3];
  assign m11_o     = m[4];
  assign m12_o     = m[5];
  assign m20_o     = m[6];
  assign m21_o     = m[7];
  assign m22_o     = m[8];
  assign trans_x_o = trn_q[ITB_LAT-3].x;
  assign trans_y_o = trn_q[ITB_LAT-3].y;
  assign trans_z_o = trn_q[ITB_LAT-3].z;

endmodule

FILE: design/itb_xform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itb_xform
// Pipelined rotation and scale datapath: angle reduction, table lookup,
// matrix products, fixed-point conversion, scale division and saturation.
// ----------------------------------------------------------------------------
module itb_xform #(
  parameter int TRIG_FRAC_BITS = itb_pkg::ITB_TRIG_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic [31:0]        angle_x_i,
  input  logic [31:0]        angle_y_i,
  input  logic [31:0]        angle_z_i,
  input  logic [17:0]        num_i [3],
  input  logic               uni_i,
  output logic signed [31:0] m_o [9]
);
  import itb_pkg::*;

  localparam int F  = TRIG_FRAC_BITS;
  localparam int W  = F + 2;
  localparam int P  = 2 * W;
  localparam int E  = P + 1;
  localparam int QW = 36;
  localparam int VW = QW + 19;
  localparam int SH = 2 * F - 32;
  localparam rom_t SIN_ROM = build_sin_rom(F);

  localparam logic [27:0] M125 = 28'd137438954;
  localparam logic [27:0] M5   = 28'd214748365;

  localparam logic [1:0] ROW [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};

  function automatic logic signed [W-1:0] sin_deg(logic [8:0] d);
    logic [8:0]   idx;
    logic         neg;
    logic [W-1:0] mag;
    if (d < 9'd90) begin
      idx = d;
      neg = 1'b0;
    end else if (d < 9'd180) begin
      idx = 9'd180 - d;
      neg = 1'b0;
    end else if (d < 9'd270) begin
      idx = d - 9'd180;
      neg = 1'b1;
    end else begin
      idx = 9'd360 - d;
      neg = 1'b1;
    end
    mag = SIN_ROM[idx[6:0]][W-1:0];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [W-1:0] rnd_f(logic signed [P-1:0] v);
    logic [P-1:0] mag;
    mag = v[P-1] ? P'(-v) : P'(v);
    mag = (mag + (P'(1) << (F - 1))) >> F;
    return v[P-1] ? -$signed(mag[W-1:0]) : $signed(mag[W-1:0]);
  endfunction

  logic [15:0]          y2_q [3];
  logic [8:0]           deg_q [3];
  logic signed [W-1:0]  s_q [3];
  logic signed [W-1:0]  c_q [3];
  logic signed [P-1:0]  pr4_q [9];
  logic signed [P-1:0]  pr5_q [9];
  logic signed [P-1:0]  pr6_q [9];
  logic signed [W-1:0]  s1_4_q, s2_4_q, s1_5_q, s2_5_q, s2_6_q;
  logic signed [W-1:0]  rnd_q [4];
  logic signed [P-1:0]  t6_q [4];
  logic signed [E-1:0]  e_q [9];
  logic signed [QW-1:0] q32_q [9];
  logic signed [VW-1:0] v_q [9];
  logic [39:0]          w_q [9];
  logic                 neg10_q [9];
  logic [20:0]          qh_q [9];
  logic [20:0]          h_q [9];
  logic [18:0]          l11_q [9];
  logic                 neg11_q [9];
  logic [20:0]          qh12_q [9];
  logic [25:0]          x2_q [9];
  logic                 neg12_q [9];
  logic [20:0]          qh13_q [9];
  logic [25:0]          q2_q [9];
  logic                 neg13_q [9];
  logic [17:0]          num_q [8][3];
  logic                 uni_q [12];

  logic [20:0] fold1 [3];
  logic [29:0] recip [3];
  logic [6:0]  quo [3];
  logic [8:0]  rem [3];
  logic [8:0]  dn [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fold1[i] = 21'({angle_x_i[31:16], 4'b0});
      fold1[i] = 21'({(i == 0) ? angle_x_i[31:16] : (i == 1) ? angle_y_i[31:16]
                       : angle_z_i[31:16], 4'b0})
               + 21'((i == 0) ? angle_x_i[15:0] : (i == 1) ? angle_y_i[15:0]
                       : angle_z_i[15:0]);
      recip[i] = 30'(y2_q[i]) * 30'd11651;
      quo[i]   = recip[i][28:22];
      rem[i]   = 9'(y2_q[i] - 16'(quo[i]) * 16'd360);
      if (i == 2) begin
        dn[i] = rem[i];
      end else begin
        dn[i] = (rem[i] == 9'd0) ? 9'd0 : 9'd360 - rem[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      y2_q[i]  <= 16'(fold1[i][20:12]) * 16'd136 + 16'(fold1[i][11:0]);
      deg_q[i] <= dn[i];
      s_q[i]   <= sin_deg(deg_q[i]);
      c_q[i]   <= sin_deg((deg_q[i] >= 9'd270) ? deg_q[i] - 9'd270 : deg_q[i] + 9'd90);
    end
  end

  // Index 0 is the X angle (s1, c1), 1 the Y angle (s2, c2), 2 the Z angle.
  always_ff @(posedge clk_i) begin
    pr4_q[0] <= P'(c_q[2] * c_q[1]);
    pr4_q[1] <= P'(s_q[2] * c_q[1]);
    pr4_q[2] <= P'(c_q[2] * s_q[0]);
    pr4_q[3] <= P'(s_q[2] * c_q[0]);
    pr4_q[4] <= P'(s_q[1] * s_q[2]);
    pr4_q[5] <= P'(c_q[2] * c_q[0]);
    pr4_q[6] <= P'(c_q[1] * s_q[0]);
    pr4_q[7] <= P'(c_q[1] * c_q[0]);
    pr4_q[8] <= P'(s_q[2] * s_q[0]);
    s1_4_q   <= s_q[0];
    s2_4_q   <= s_q[1];
    pr5_q    <= pr4_q;
    s1_5_q   <= s1_4_q;
    s2_5_q   <= s2_4_q;
    rnd_q[0] <= rnd_f(pr4_q[2]);
    rnd_q[1] <= rnd_f(pr4_q[4]);
    rnd_q[2] <= rnd_f(pr4_q[5]);
    rnd_q[3] <= rnd_f(pr4_q[3]);
    pr6_q    <= pr5_q;
    s2_6_q   <= s2_5_q;
    t6_q[0]  <= P'(rnd_q[0] * s2_5_q);
    t6_q[1]  <= P'(rnd_q[1] * s1_5_q);
    t6_q[2]  <= P'(rnd_q[2] * s2_5_q);
    t6_q[3]  <= P'(rnd_q[3] * s2_5_q);
    e_q[0]   <= E'(pr6_q[0]);
    e_q[1]   <= E'(pr6_q[1]);
    e_q[2]   <= -(E'(s2_6_q) <<< F);
    e_q[3]   <= E'(t6_q[0]) - E'(pr6_q[3]);
    e_q[4]   <= E'(t6_q[1]) + E'(pr6_q[5]);
    e_q[5]   <= E'(pr6_q[6]);
    e_q[6]   <= E'(t6_q[2]) + E'(pr6_q[8]);
    e_q[7]   <= E'(t6_q[3]) - E'(pr6_q[2]);
    e_q[8]   <= E'(pr6_q[7]);
  end

  logic [E-1:0] emag [9];
  logic [E-1:0] erm [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      emag[i] = e_q[i][E-1] ? E'(-e_q[i]) : E'(e_q[i]);
      if (SH > 0) begin
        erm[i] = (emag[i] + (E'(1) << (SH - 1))) >> SH;
      end else begin
        erm[i] = emag[i] << (-SH);
      end
    end
  end

  logic [VW-1:0] vmag [9];
  logic [VW-1:0] tt [9];
  logic [48:0]   hp [9];
  logic [7:0]    dv [9];
  logic [20:0]   rh [9];
  logic [53:0]   lp [9];
  logic [39:0]   qs [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      vmag[i] = v_q[i][VW-1] ? VW'(-v_q[i]) : VW'(v_q[i]);
      tt[i]   = (vmag[i] + (uni_q[8] ? VW'(512000) : VW'(10240))) >> 10;
      tt[i]   = uni_q[8] ? (tt[i] >> 3) : (tt[i] >> 2);
      hp[i]   = 49'(w_q[i][39:19]) * 49'(uni_q[9] ? M125 : M5);
      dv[i]   = uni_q[10] ? 8'd125 : 8'd5;
      rh[i]   = h_q[i] - 21'(qh_q[i] * 21'(dv[i]));
      lp[i]   = 54'(x2_q[i]) * 54'(uni_q[11] ? M125 : M5);
      qs[i]   = {qh13_q[i], 19'b0} + 40'(q2_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    num_q[0] <= num_i;
    uni_q[0] <= uni_i;
    for (int k = 1; k < 8; k++) begin
      num_q[k] <= num_q[k-1];
    end
    for (int k = 1; k < 12; k++) begin
      uni_q[k] <= uni_q[k-1];
    end
    for (int i = 0; i < 9; i++) begin
      q32_q[i]   <= e_q[i][E-1] ? -$signed(QW'(erm[i])) : $signed(QW'(erm[i]));
      v_q[i]     <= VW'(q32_q[i] * $signed({1'b0, num_q[7][ROW[i]]}));
      w_q[i]     <= tt[i][39:0];
      neg10_q[i] <= v_q[i][VW-1];
      qh_q[i]    <= uni_q[9] ? 21'(hp[i][48:34]) : 21'(hp[i][48:30]);
      h_q[i]     <= w_q[i][39:19];
      l11_q[i]   <= w_q[i][18:0];
      neg11_q[i] <= neg10_q[i];
      qh12_q[i]  <= qh_q[i];
      x2_q[i]    <= {rh[i][6:0], l11_q[i]};
      neg12_q[i] <= neg11_q[i];
      qh13_q[i]  <= qh12_q[i];
      q2_q[i]    <= uni_q[11] ? 26'(lp[i][53:34]) : 26'(lp[i][53:30]);
      neg13_q[i] <= neg12_q[i];
      if (neg13_q[i]) begin
        m_o[i] <= (qs[i] > 40'h80000000) ? 32'sh80000000 : -$signed(qs[i][31:0]);
      end else begin
        m_o[i] <= (qs[i] > 40'h7fffffff) ? 32'sh7fffffff : $signed(qs[i][31:0]);
      end
    end
  end

endmodule

FILE: design/itb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itb_checker
// Port-level checks on beat timing and pass-through translation fields.
// ----------------------------------------------------------------------------
module itb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               valid_o,
  input logic signed [31:0] pos_x_i,
  input logic signed [31:0] pos_z_i,
  input logic signed [31:0] trans_x_o,
  input logic signed [31:0] trans_z_o
);
  import itb_pkg::*;

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy asserted");

  a_valid_from_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, ITB_LAT))
    else $error("result beat without a matching input beat");

  a_trans_x : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> trans_x_o == $past(pos_x_i, ITB_LAT))
    else $error("translation x mismatch");

  a_trans_z : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> trans_z_o == $past(pos_z_i, ITB_LAT))
    else $error("translation z mismatch");

endmodule

bind instance_transform_builder_top itb_checker u_itb_checker (.*);
